### hdl/spq_pkg.sv
// Shared types, codes and default sizes for the strict priority multi-queue.
package spq_pkg;

    localparam int LEVELS_DEF      = 8;
    localparam int LEVEL_DEPTH_DEF = 16;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_PRI = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] task_id;
        logic [3:0]  priority_req;
    } t_in_item;

    typedef struct packed {
        logic        found;
        logic [15:0] out_task_id;
        logic [3:0]  out_priority;
        logic [7:0]  total_count;
        logic [4:0]  level_count;
        logic [1:0]  status;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic exec;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic out_valid;
    } t_dp_status;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DONE = 3'b100
    } t_state;

endpackage

### hdl/spq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module spq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/spq_ctrl.sv
// Sequencer for the multi-queue: accept, execute, finish.
module spq_ctrl
    import spq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   accept;

    // Take an item only out of reset, in idle, and when the result slot is free or drains this cycle.
    assign o_in_ready = i_rst_n && (r_state == S_IDLE) &&
                        (!i_status.out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept) n_state = S_EXEC;
            S_EXEC: n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.capture = accept;
    assign o_cmd.exec    = (r_state == S_EXEC);
    assign o_cmd.finish  = (r_state == S_DONE);

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready)
        else $error("ready raised while an item is in flight");

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC) ##1 (r_state == S_DONE))
        else $error("item did not run exec then finish");

    a_finish_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> !i_status.out_valid)
        else $error("result produced while output slot still full");

endmodule

### hdl/spq_datapath.sv
// Queue state, task RAM and result register for the multi-queue.
module spq_datapath
    import spq_pkg::*;
#(
    parameter int LEVELS      = LEVELS_DEF,
    parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  t_in_item   i_in_item,
    input  logic       i_out_ready,
    output t_dp_status o_status,
    output logic       o_out_valid,
    output t_out_item  o_out_item
);

    localparam int LW = $clog2(LEVELS);
    localparam int PW = $clog2(LEVEL_DEPTH);
    localparam int FW = $clog2(LEVEL_DEPTH + 1);
    localparam int SD = LEVELS * LEVEL_DEPTH;
    localparam int AW = $clog2(SD);
    localparam int TW = $clog2(SD + 1);

    t_in_item        r_in;
    logic [PW-1:0]   r_head [LEVELS];
    logic [PW-1:0]   r_tail [LEVELS];
    logic [FW-1:0]   r_fill [LEVELS];
    logic [PW-1:0]   n_head [LEVELS];
    logic [PW-1:0]   n_tail [LEVELS];
    logic [FW-1:0]   n_fill [LEVELS];
    logic [TW-1:0]   r_total, n_total;
    logic            r_found;
    logic [LW-1:0]   r_top;
    logic [1:0]      r_stat;
    logic            r_out_valid, n_out_valid;
    t_out_item       r_out;

    logic            pr_valid, is_push, is_pop, any, push_ok, pop_ok;
    logic [LW-1:0]   lv, top, sel, f_idx;
    logic [FW-1:0]   f_rd;
    logic [PW-1:0]   sel_head, sel_tail, ptr;
    logic [31:0]     addr_w, fill_w, pri_w, total_w;
    logic [AW-1:0]   addr;
    logic            we;
    logic [15:0]     rdata;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign pr_valid = (r_in.priority_req != 4'd0) &&
                      ({1'b0, r_in.priority_req} <= 5'(LEVELS));
    assign lv       = LW'(r_in.priority_req - 4'd1);
    assign is_push  = (r_in.opcode == OP_PUSH);
    assign is_pop   = (r_in.opcode == OP_POP);

    // Highest non-empty level wins.
    always_comb begin
        top = '0;
        any = 1'b0;
        for (int i = 0; i < LEVELS; i++) begin
            if (r_fill[i] != '0) begin
                top = LW'(i);
                any = 1'b1;
            end
        end
    end

    assign sel      = is_push ? lv : top;
    assign f_idx    = i_cmd.exec ? sel : lv;
    assign f_rd     = r_fill[f_idx];
    assign sel_head = r_head[sel];
    assign sel_tail = r_tail[sel];
    assign push_ok  = is_push && pr_valid && (f_rd != FW'(LEVEL_DEPTH));
    assign pop_ok   = is_pop && any;

    assign ptr    = is_push ? sel_tail : sel_head;
    assign addr_w = 32'(sel) * LEVEL_DEPTH + 32'(ptr);
    assign addr   = addr_w[AW-1:0];
    assign we     = i_cmd.exec && push_ok;

    spq_ram #(
        .WIDTH (16),
        .DEPTH (SD)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (addr),
        .i_wdata (r_in.task_id),
        .i_raddr (addr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_fill  = r_fill;
        n_total = r_total;
        if (i_cmd.exec && push_ok) begin
            n_tail[sel] = ptr_inc(sel_tail);
            n_fill[sel] = f_rd + 1'b1;
            n_total     = r_total + 1'b1;
        end else if (i_cmd.exec && pop_ok) begin
            n_head[sel] = ptr_inc(sel_head);
            n_fill[sel] = f_rd - 1'b1;
            n_total     = r_total - 1'b1;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEVELS; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_fill[i] <= '0;
            end
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_fill      <= n_fill;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    assign fill_w  = pr_valid ? 32'(f_rd) : 32'd0;
    assign pri_w   = 32'(r_top) + 32'd1;
    assign total_w = 32'(r_total);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in_item;
        end
        // Hold per-item decisions from exec for the finish cycle.
        if (i_cmd.exec) begin
            r_found <= !is_push && any;
            r_top   <= top;
            if (is_push) begin
                r_stat <= !pr_valid ? ST_BAD_PRI : (push_ok ? ST_OK : ST_FULL);
            end else begin
                r_stat <= any ? ST_OK : ST_EMPTY;
            end
        end
        if (i_cmd.finish) begin
            r_out.found        <= r_found;
            r_out.out_task_id  <= r_found ? rdata : 16'd0;
            r_out.out_priority <= r_found ? pri_w[3:0] : 4'd0;
            r_out.total_count  <= total_w[7:0];
            r_out.level_count  <= fill_w[4:0];
            r_out.status       <= r_stat;
        end
    end

    assign o_status.out_valid = r_out_valid;
    assign o_out_valid        = r_out_valid;
    assign o_out_item         = r_out;

    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && pop_ok) |=> (r_total == $past(r_total) - 1'b1))
        else $error("pop did not reduce total count");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.found) |-> (r_out.status == ST_OK))
        else $error("task returned with a failing status");

    a_no_write_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (r_fill[sel] < FW'(LEVEL_DEPTH)) && pr_valid)
        else $error("write into full or invalid level");

endmodule

### hdl/strict_priority_multi_queue_top.sv
// Top level of the strict priority multi-queue: controller plus datapath.
//
//   channel   direction  handshake                      payload
//   input     in         i_in_valid / o_in_ready        i_in_item  (t_in_item)
//   output    out        o_out_valid / i_out_ready      o_out_item (t_out_item)
//
// Each item runs through accept, execute (level select and RAM access) and finish
// (registered RAM read and level count into the result register).
// The next item is accepted in the cycle after finish if the result slot is free
// or is taken in that cycle, so no new item is taken until the last one has finished.
// Reset clears pointers, fill counts and the total at once; no clearing pass.
// A stalled result holds in its register and blocks further accepts.
module strict_priority_multi_queue_top
    import spq_pkg::*;
#(
    parameter int LEVELS      = LEVELS_DEF,
    parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_dp_cmd    cmd;
    t_dp_status status;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_in_ready  (o_in_ready),
        .o_cmd       (cmd)
    );

    spq_datapath #(
        .LEVELS      (LEVELS),
        .LEVEL_DEPTH (LEVEL_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_item   (i_in_item),
        .i_out_ready (i_out_ready),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
